>>> sv/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the treadmill routine sequencer
// item and result payloads, mode and operation codes, controller/datapath links
// ----------------------------------------------------------------------------
package trs_pkg;

    // operation codes of an input item
    typedef enum logic [1:0]
    {
        OP_TICK     = 2'd0,
        OP_MODE     = 2'd1,
        OP_SETPOINT = 2'd2,
        OP_POINT    = 2'd3
    } trs_op_t;

    // operating modes
    typedef enum logic [1:0]
    {
        MODE_STOP  = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_RUN   = 2'd3
    } trs_mode_t;

    // configuration register indexes
    localparam int              CFG_INDEX_W     = 2;
    localparam int              CFG_DATA_W      = 16;
    localparam logic [1:0]      CFG_GAIN        = 2'd0;
    localparam logic [1:0]      CFG_MAX_MOTOR   = 2'd1;
    localparam logic [1:0]      CFG_MAX_MISSING = 2'd2;

    // register reset values and fixed limits
    localparam logic [7:0]      GAIN_RESET        = 8'd10;
    localparam logic [14:0]     MAX_MOTOR_RESET   = 15'd100;
    localparam logic [3:0]      MAX_MISSING_RESET = 4'd15;
    localparam logic [3:0]      MISSING_SAT       = 4'd15;

    // gain (9 bit signed) times error (17 bit signed)
    localparam int              PROD_W          = 26;
    localparam int              POSITION_W      = 9;

    typedef struct packed
    {
        logic [1:0]         operation;
        logic [1:0]         mode_request;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [31:0]        duration_ms;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic               speed_valid;
        logic [31:0]        now_ms;
    } trs_in_t;

    typedef struct packed
    {
        logic signed [15:0] motor_x;
        logic signed [15:0] motor_y;
        logic               motors_running;
        logic [1:0]         current_mode;
        logic [8:0]         point_position;
        logic               point_loaded;
        logic               routine_too_long;
        logic signed [15:0] active_target_x;
        logic signed [15:0] active_target_y;
    } trs_out_t;

    // one routine point as kept in the point store
    typedef struct packed
    {
        logic [31:0]        duration_ms;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } trs_point_t;

    // controller states
    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_ADVANCE,
        ST_SET_RUN,
        ST_SET_WRAP,
        ST_CTRL,
        ST_MUL_Y,
        ST_CLAMP_Y,
        ST_FINISH
    } trs_state_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0]
    {
        DP_NONE,
        DP_TICK_STOP,
        DP_LOAD_CHECK,
        DP_RD_CUR,
        DP_RD_NEXT,
        DP_ADV_SET,
        DP_WRAP,
        DP_SET_FROM_RD,
        DP_MODE,
        DP_RUN_REQ,
        DP_SETPOINT,
        DP_POINT,
        DP_MISS,
        DP_MUL_X,
        DP_MUL_Y,
        DP_CLAMP_Y
    } trs_dp_op_t;

    typedef struct packed
    {
        logic       capture;
        logic       finish;
        trs_dp_op_t op;
    } trs_cmd_t;

    typedef struct packed
    {
        trs_op_t    op;
        trs_mode_t  req;
        trs_mode_t  mode;
        logic       speed_valid;
        logic       run_go;
        logic       dur_zero;
    } trs_status_t;

endpackage

>>> sv/trs_ram.sv
// ----------------------------------------------------------------------------
// trs_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module trs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/trs_ctrl.sv
// ----------------------------------------------------------------------------
// trs_ctrl: sequencer state machine
// walks one item through decode, store reads, control step and result
// ----------------------------------------------------------------------------
module trs_ctrl
    import trs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  trs_status_t status,
    output trs_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    trs_state_t state_reg;
    trs_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '{capture: 1'b0, finish: 1'b0, op: DP_NONE};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_TICK:
                    begin
                        unique case (status.mode)
                            MODE_STOP:
                            begin
                                cmd.op     = DP_TICK_STOP;
                                state_next = ST_FINISH;
                            end
                            MODE_SPEED:
                            begin
                                state_next = ST_CTRL;
                            end
                            MODE_LOAD:
                            begin
                                cmd.op     = DP_LOAD_CHECK;
                                state_next = ST_FINISH;
                            end
                            default:
                            begin
                                cmd.op     = DP_RD_CUR;
                                state_next = ST_CHECK;
                            end
                        endcase
                    end
                    OP_MODE:
                    begin
                        if (status.req == MODE_RUN && status.mode == MODE_LOAD)
                        begin
                            cmd.op     = DP_RUN_REQ;
                            state_next = ST_SET_RUN;
                        end
                        else
                        begin
                            cmd.op     = DP_MODE;
                            state_next = ST_FINISH;
                        end
                    end
                    OP_SETPOINT:
                    begin
                        cmd.op     = DP_SETPOINT;
                        state_next = ST_FINISH;
                    end
                    default:
                    begin
                        cmd.op     = DP_POINT;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (status.run_go)
                begin
                    cmd.op     = DP_RD_NEXT;
                    state_next = ST_ADVANCE;
                end
                else
                begin
                    state_next = ST_CTRL;
                end
            end
            ST_ADVANCE:
            begin
                if (status.dur_zero)
                begin
                    cmd.op     = DP_WRAP;
                    state_next = ST_SET_WRAP;
                end
                else
                begin
                    cmd.op     = DP_ADV_SET;
                    state_next = ST_CTRL;
                end
            end
            ST_SET_RUN:
            begin
                cmd.op     = DP_SET_FROM_RD;
                state_next = ST_FINISH;
            end
            ST_SET_WRAP:
            begin
                cmd.op     = DP_SET_FROM_RD;
                state_next = ST_CTRL;
            end
            ST_CTRL:
            begin
                if (status.speed_valid)
                begin
                    cmd.op     = DP_MUL_X;
                    state_next = ST_MUL_Y;
                end
                else
                begin
                    cmd.op     = DP_MISS;
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_Y:
            begin
                cmd.op     = DP_MUL_Y;
                state_next = ST_CLAMP_Y;
            end
            ST_CLAMP_Y:
            begin
                cmd.op     = DP_CLAMP_Y;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

>>> sv/trs_dp.sv
// ----------------------------------------------------------------------------
// trs_dp: sequencer datapath
// mode and point state, point store, shared drive multiplier, result register
// ----------------------------------------------------------------------------
module trs_dp
    import trs_pkg::*;
#(
    parameter int ROUTINE_POINTS = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  trs_in_t                item,
    input  trs_cmd_t               cmd,
    output trs_status_t            status,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output trs_out_t               result
);

    localparam int              AW        = $clog2(ROUTINE_POINTS);
    localparam int              IW        = $clog2(ROUTINE_POINTS + 1);
    localparam logic [IW-1:0]   IDX_FULL  = IW'(ROUTINE_POINTS);
    localparam logic [AW-1:0]   SLOT_LAST = AW'(ROUTINE_POINTS - 1);
    localparam logic signed [PROD_W-1:0] DRIVE_FLOOR = PROD_W'(-32768);

    // configuration
    logic [7:0]         gain_reg;
    logic [14:0]        max_motor_reg;
    logic [3:0]         max_missing_reg;

    // control state
    trs_mode_t          mode_reg;
    logic [IW-1:0]      index_reg;
    logic [IW-1:0]      fill_reg;
    logic [31:0]        start_time_reg;
    logic signed [15:0] set_x_reg;
    logic signed [15:0] set_y_reg;
    logic signed [15:0] mot_x_reg;
    logic signed [15:0] mot_y_reg;
    logic [3:0]         missing_reg;
    logic               loaded_reg;
    logic               too_long_reg;
    logic [AW-1:0]      cur_reg;

    // payload
    trs_in_t            item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               rd_hit_reg;
    trs_out_t           result_reg;

    logic [AW-1:0]      slot;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [$bits(trs_point_t)-1:0] rd_word;
    trs_point_t         rd_point;
    trs_point_t         wr_point;
    logic               wr_en;
    logic [31:0]        elapsed;
    logic [3:0]         miss_next;
    logic signed [16:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [IW+POSITION_W-1:0] index_wide;
    trs_out_t           result_next;

    function automatic logic signed [15:0] clamp_drive(
        input logic signed [PROD_W-1:0] p,
        input logic [14:0]              lim
    );
        logic signed [PROD_W-1:0] hi;
        hi = $signed({{(PROD_W-15){1'b0}}, lim});
        if (p > hi)
        begin
            clamp_drive = $signed({1'b0, lim});
        end
        else if (p < DRIVE_FLOOR)
        begin
            clamp_drive = 16'sh8000;
        end
        else
        begin
            clamp_drive = p[15:0];
        end
    endfunction

    // point store: a fill mark stands in for the clear at reset, since
    // loads always land at the next free slot or at a slot already written
    trs_ram #(
        .WIDTH ($bits(trs_point_t)),
        .DEPTH (ROUTINE_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (index_reg[AW-1:0]),
        .wdata (wr_point),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    assign slot     = (index_reg < IDX_FULL) ? index_reg[AW-1:0] : '0;
    assign rd_point = rd_hit_reg ? trs_point_t'(rd_word) : '0;
    assign wr_en    = (cmd.op == DP_POINT) && (mode_reg == MODE_LOAD)
                      && (index_reg < IDX_FULL);
    assign wr_point = '{duration_ms: item_reg.duration_ms,
                        target_x:    item_reg.target_x,
                        target_y:    item_reg.target_y};
    assign elapsed  = item_reg.now_ms - start_time_reg;
    assign miss_next = (missing_reg == MISSING_SAT) ? MISSING_SAT : missing_reg + 1'b1;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (cmd.op) inside
            DP_RD_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = slot;
            end
            DP_RD_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg + 1'b1;
            end
            DP_WRAP, DP_RUN_REQ:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            default:
            begin
            end
        endcase
    end

    // one shared multiplier, x then y
    always_comb
    begin
        if (cmd.op == DP_MUL_Y)
        begin
            diff = $signed({set_y_reg[15], set_y_reg})
                 - $signed({item_reg.speed_y[15], item_reg.speed_y});
        end
        else
        begin
            diff = $signed({set_x_reg[15], set_x_reg})
                 - $signed({item_reg.speed_x[15], item_reg.speed_x});
        end
        prod = $signed({1'b0, gain_reg}) * diff;
    end

    always_comb
    begin
        status.op          = trs_op_t'(item_reg.operation);
        status.req         = trs_mode_t'(item_reg.mode_request);
        status.mode        = mode_reg;
        status.speed_valid = item_reg.speed_valid;
        status.run_go      = (elapsed >= rd_point.duration_ms) && (cur_reg != SLOT_LAST);
        status.dur_zero    = (rd_point.duration_ms == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_RESET;
            max_motor_reg   <= MAX_MOTOR_RESET;
            max_missing_reg <= MAX_MISSING_RESET;
            mode_reg        <= MODE_STOP;
            index_reg       <= '0;
            fill_reg        <= '0;
            start_time_reg  <= '0;
            set_x_reg       <= '0;
            set_y_reg       <= '0;
            mot_x_reg       <= '0;
            mot_y_reg       <= '0;
            missing_reg     <= '0;
            loaded_reg      <= 1'b0;
            too_long_reg    <= 1'b0;
            cur_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_GAIN:        gain_reg        <= cfg_data[7:0];
                    CFG_MAX_MOTOR:   max_motor_reg   <= cfg_data[14:0];
                    CFG_MAX_MISSING: max_missing_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.capture)
            begin
                loaded_reg   <= 1'b0;
                too_long_reg <= 1'b0;
            end
            case (cmd.op)
                DP_TICK_STOP:
                begin
                    set_x_reg <= '0;
                    set_y_reg <= '0;
                    mot_x_reg <= '0;
                    mot_y_reg <= '0;
                end
                DP_LOAD_CHECK:
                begin
                    too_long_reg <= (index_reg == IDX_FULL);
                end
                DP_RD_CUR:
                begin
                    cur_reg <= slot;
                end
                DP_ADV_SET:
                begin
                    index_reg      <= IW'(cur_reg) + 1'b1;
                    set_x_reg      <= rd_point.target_x;
                    set_y_reg      <= rd_point.target_y;
                    start_time_reg <= item_reg.now_ms;
                end
                DP_WRAP:
                begin
                    index_reg      <= '0;
                    start_time_reg <= item_reg.now_ms;
                end
                DP_SET_FROM_RD:
                begin
                    set_x_reg <= rd_point.target_x;
                    set_y_reg <= rd_point.target_y;
                end
                DP_MODE:
                begin
                    case (status.req)
                        MODE_STOP:
                        begin
                            mode_reg  <= MODE_STOP;
                            index_reg <= '0;
                            mot_x_reg <= '0;
                            mot_y_reg <= '0;
                        end
                        MODE_LOAD:
                        begin
                            mode_reg <= MODE_LOAD;
                        end
                        MODE_SPEED:
                        begin
                            if (mode_reg != MODE_RUN)
                            begin
                                mode_reg <= MODE_SPEED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                DP_RUN_REQ:
                begin
                    mode_reg       <= MODE_RUN;
                    index_reg      <= '0;
                    start_time_reg <= item_reg.now_ms;
                end
                DP_SETPOINT:
                begin
                    if (mode_reg == MODE_SPEED)
                    begin
                        set_x_reg <= item_reg.target_x;
                        set_y_reg <= item_reg.target_y;
                    end
                end
                DP_POINT:
                begin
                    if (mode_reg == MODE_LOAD)
                    begin
                        if (index_reg < IDX_FULL)
                        begin
                            index_reg  <= index_reg + 1'b1;
                            loaded_reg <= 1'b1;
                            if (index_reg == fill_reg)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            too_long_reg <= 1'b1;
                        end
                    end
                end
                DP_MISS:
                begin
                    missing_reg <= miss_next;
                    if (miss_next >= max_missing_reg)
                    begin
                        mode_reg  <= MODE_STOP;
                        index_reg <= '0;
                        mot_x_reg <= '0;
                        mot_y_reg <= '0;
                    end
                end
                DP_MUL_X:
                begin
                    missing_reg <= '0;
                end
                DP_MUL_Y:
                begin
                    mot_x_reg <= clamp_drive(prod_reg, max_motor_reg);
                end
                DP_CLAMP_Y:
                begin
                    mot_y_reg <= clamp_drive(prod_reg, max_motor_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign index_wide = {{POSITION_W{1'b0}}, index_reg};

    always_comb
    begin
        result_next.motor_x          = mot_x_reg;
        result_next.motor_y          = mot_y_reg;
        result_next.motors_running   = (mode_reg == MODE_SPEED) || (mode_reg == MODE_RUN);
        result_next.current_mode     = mode_reg;
        result_next.point_position   = index_wide[POSITION_W-1:0];
        result_next.point_loaded     = loaded_reg;
        result_next.routine_too_long = too_long_reg;
        result_next.active_target_x  = set_x_reg;
        result_next.active_target_y  = set_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.op == DP_MUL_X || cmd.op == DP_MUL_Y)
        begin
            prod_reg <= prod;
        end
        if (rd_en)
        begin
            rd_hit_reg <= (IW'(rd_addr) < fill_reg);
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> sv/treadmill_routine_sequencer_top.sv
// ----------------------------------------------------------------------------
// treadmill_routine_sequencer_top: two-axis speed controller with routine
// stop, speed, routine load and routine run modes, one result per item
// ----------------------------------------------------------------------------
// steps: every item is decoded and then finished; a run request first reads point 0;
//   a speed tick adds control and drive steps, a run tick store reads before those
// throughput: one item at a time, next start taken in the cycle done is high
// the run path is set by the point store's registered read port (up to three
//   reads in a row) and the one multiplier shared by both axes
// reset: asynchronous, clears modes, setpoints, drive and the store fill mark
//   at once; no clearing pass; done is a one-cycle strobe the receiver cannot stall
module treadmill_routine_sequencer_top
    import trs_pkg::*;
#(
    parameter int ROUTINE_POINTS = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // item side: transfer when start is high and busy is low
    input  logic                   start,
    output logic                   busy,
    input  trs_in_t                item,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // result side: valid for the single cycle that done is high
    output logic                   done,
    output trs_out_t               result
);

    trs_cmd_t    cmd;
    trs_status_t status;

    // registers are plain flops, a write always completes
    assign cfg_ready = 1'b1;

    // controller: one state per step of an item
    trs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: state registers, point store, drive multiplier
    trs_dp #(
        .ROUTINE_POINTS (ROUTINE_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    // a result only follows an item in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in flight");

    // an accepted item keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item transfer did not start work");

    // drive is zero whenever the block sits in stop mode
    a_stop_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.current_mode == MODE_STOP)
            |-> (result.motor_x == 16'sd0 && result.motor_y == 16'sd0))
        else $error("nonzero drive in stop mode");

    // points are stored only in load mode
    a_load_mode_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.point_loaded) |-> (result.current_mode == MODE_LOAD))
        else $error("point stored outside load mode");

endmodule
